// File: src/windowed_vote_pulse_counter_top_defines.svh
// Assertion macros used by the checker file.
`ifndef WINDOWED_VOTE_PULSE_COUNTER_TOP_DEFINES_SVH
`define WINDOWED_VOTE_PULSE_COUNTER_TOP_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define WVPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define WVPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/wvpc_pkg.sv
package wvpc_pkg;

    // Field widths fixed by the stream formats
    localparam int THR_W        = 3;
    localparam int TOTAL_W      = 16;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 24;
    localparam int OUT_PAD_W    = OUT_TDATA_W - TOTAL_W - 1;

    // Threshold after reset
    localparam logic [THR_W-1:0] THR_RESET = 3'd3;

    // Command codes
    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_READ   = 1'b1
    } t_cmd;

    // One input item between the input register and the core
    typedef struct packed {
        t_cmd cmd;
        logic raw;
    } t_item;

endpackage

// File: src/wvpc_in_reg.sv
module wvpc_in_reg
    import wvpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_core_ready
);

    logic  r_valid;
    t_item r_item;

    // Take a new item whenever the held one is empty or moving on
    assign o_ready = !r_valid || i_core_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load the payload on accept
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: src/wvpc_core.sv
module wvpc_core
    import wvpc_pkg::*;
#(
    parameter int WINDOW     = 5,
    parameter int COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [THR_W-1:0]   i_cfg_wdata,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_ready,
    output logic               o_valid,
    output logic [TOTAL_W-1:0] o_total,
    output logic               o_level,
    input  logic               i_out_ready
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = $clog2(WINDOW + 1);
    localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    logic [THR_W-1:0]      r_thr;
    logic [WINDOW-1:0]     r_window;
    logic [WINDOW-1:0]     n_window;
    logic [SLOT_W-1:0]     r_slot;
    logic [SLOT_W-1:0]     n_slot;
    logic [SUM_W-1:0]      r_sum;
    logic [SUM_W-1:0]      n_sum;
    logic                  r_level;
    logic                  n_level;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic                  r_out_valid;
    logic [TOTAL_W-1:0]    r_out_total;
    logic                  r_out_level;
    logic [TOTAL_W-1:0]    w_total;
    logic [CMP_W-1:0]      w_sum_x;
    logic [CMP_W-1:0]      w_thr_x;
    logic                  w_fire;

    assign o_ready = !r_out_valid || i_out_ready;
    assign w_fire  = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_total = r_out_total;
    assign o_level = r_out_level;

    // Report the low bits of the count, zero-extend a narrow one
    if (COUNT_BITS >= TOTAL_W) begin : g_total_cut
        assign w_total = r_count[TOTAL_W-1:0];
    end else begin : g_total_ext
        assign w_total = {{(TOTAL_W - COUNT_BITS){1'b0}}, r_count};
    end

    // On a sample advance the ring, update the running sum, vote and count falls; a read clears the count
    always_comb begin
        n_window = r_window;
        n_slot   = r_slot;
        n_sum    = r_sum;
        n_level  = r_level;
        n_count  = r_count;
        w_sum_x  = '0;
        w_thr_x  = CMP_W'(r_thr);
        if (i_item.cmd == CMD_READ) begin
            n_count = '0;
        end else begin
            n_window[r_slot] = i_item.raw;
            n_slot  = (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);
            n_sum   = r_sum - SUM_W'(r_window[r_slot]) + SUM_W'(i_item.raw);
            w_sum_x = CMP_W'(n_sum);
            if (w_sum_x < w_thr_x) begin
                if (r_level) begin
                    n_level = 1'b0;
                    if (r_count != '1) begin
                        n_count = r_count + COUNT_BITS'(1);
                    end
                end
            end else if (w_sum_x > w_thr_x) begin
                n_level = 1'b1;
            end
        end
    end

    // Hold the threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // Hold debounce state and the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '1;
            r_slot      <= '0;
            r_sum       <= SUM_W'(WINDOW);
            r_level     <= 1'b1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (w_fire) begin
                r_window <= n_window;
                r_slot   <= n_slot;
                r_sum    <= n_sum;
                r_level  <= n_level;
                r_count  <= n_count;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_total <= w_total;
            r_out_level <= n_level;
        end
    end

endmodule

// File: src/windowed_vote_pulse_counter_top.sv
// Channel   | Direction | Handshake           | Payload
// s (items) | in        | i_s_tvalid/o_s_tready | tuser: command; tdata: raw_level
// m (items) | out       | o_m_tvalid/i_m_tready | tdata: pulse_total, qualified_level
// cfg       | in        | i_cfg_we            | i_cfg_wdata: vote_threshold
//
// One item per cycle sustained while m does not stall; each item passes the input register, then the result register.
// The ring update, running-sum vote and count step sit between the input
// register and the result register.
// Reset (synchronous, active low) sets the ring to all high, level high, count zero.
// A stall on the m side fills the result register, then the input register,
// then drops o_s_tready.
module windowed_vote_pulse_counter_top
    import wvpc_pkg::*;
#(
    parameter int WINDOW     = 5,
    parameter int COUNT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [THR_W-1:0]       i_cfg_wdata,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [0] raw_level, rest unused
    input  logic                   i_s_tuser,   // [0] command
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // [15:0] pulse_total, [16] qualified_level
);

    t_item              w_in_item;
    t_item              w_core_item;
    logic               w_core_valid;
    logic               w_core_ready;
    logic [TOTAL_W-1:0] w_total;
    logic               w_level;

    assign w_in_item.cmd = t_cmd'(i_s_tuser);
    assign w_in_item.raw = i_s_tdata[0];

    // Register the incoming item
    wvpc_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .i_item       (w_in_item),
        .o_ready      (o_s_tready),
        .o_valid      (w_core_valid),
        .o_item       (w_core_item),
        .i_core_ready (w_core_ready)
    );

    // Vote, count and register the result
    wvpc_core #(
        .WINDOW     (WINDOW),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (w_core_valid),
        .i_item      (w_core_item),
        .o_ready     (w_core_ready),
        .o_valid     (o_m_tvalid),
        .o_total     (w_total),
        .o_level     (w_level),
        .i_out_ready (i_m_tready)
    );

    assign o_m_tdata = {{OUT_PAD_W{1'b0}}, w_level, w_total};

endmodule

// File: src/wvpc_checker.sv
`include "windowed_vote_pulse_counter_top_defines.svh"

module wvpc_checker
    import wvpc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic               r_seen;
    logic [TOTAL_W-1:0] r_prev_total;
    logic               r_prev_level;
    logic               w_out_fire;
    logic [TOTAL_W-1:0] w_total;
    logic [TOTAL_W-1:0] w_prev_inc;

    assign w_out_fire = o_m_tvalid && i_m_tready;
    assign w_total    = o_m_tdata[TOTAL_W-1:0];
    assign w_prev_inc = r_prev_total + TOTAL_W'(1);

    // Track the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (w_out_fire) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_fire) begin
            r_prev_total <= w_total;
            r_prev_level <= o_m_tdata[TOTAL_W];
        end
    end

    `WVPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata), "stalled result changed or dropped")

    `WVPC_ASSERT_NOW(a_ready_only_on_stall, i_clk, i_rst_n, !o_s_tready,
        o_m_tvalid && !i_m_tready, "input stalled without an output stall")

    `WVPC_ASSERT_NOW(a_count_step, i_clk, i_rst_n, w_out_fire && r_seen,
        w_total == r_prev_total || w_total == w_prev_inc || w_total == '0,
        "pulse total jumped between results")

    `WVPC_ASSERT_NOW(a_count_on_fall, i_clk, i_rst_n,
        w_out_fire && r_seen && w_total == w_prev_inc && w_total != r_prev_total,
        !r_prev_level, "pulse counted without a falling level")

    // Silence nothing; input valid kept for visibility of the s channel
    logic w_s_fire;
    assign w_s_fire = i_s_tvalid && o_s_tready;

    `WVPC_ASSERT_NOW(a_accept_ready, i_clk, i_rst_n, w_s_fire,
        !(o_m_tvalid && !i_m_tready) || !r_seen || o_s_tready,
        "input accepted while not ready")

endmodule

bind windowed_vote_pulse_counter_top wvpc_checker u_wvpc_checker (.*);
